[rtl/usmg_pkg.sv]
// ============================================================================
// UV sphere mesh generator package
// Shared widths, pipeline stage numbers, payload structs and helper functions.
// ============================================================================
`default_nettype none

package usmg_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_STACKS = 2'd1;
    localparam logic [1:0] CFG_SLICES = 2'd2;

    // Request kinds.
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Register reset values.
    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [8:0]  STACKS_RST = 9'd5;
    localparam logic [8:0]  SLICES_RST = 9'd5;

    // Clamp limits of the stack and slice counts.
    localparam logic [8:0] MIN_STACKS = 9'd2;
    localparam logic [8:0] MAX_STACKS = 9'd256;
    localparam logic [8:0] MIN_SLICES = 9'd3;
    localparam logic [8:0] MAX_SLICES = 9'd256;

    // Pipeline geometry.
    localparam int DIV1_N        = 17;
    localparam int ANG_N         = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int S_PREP        = DIV1_N;
    localparam int S_ANG0        = S_PREP + 1;
    localparam int S_ROT0        = S_ANG0 + ANG_N;
    localparam int S_QUAD        = S_ROT0 + CORDIC_STAGES;
    localparam int S_MUL         = S_QUAD + 1;
    localparam int S_OUT         = S_MUL + 1;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // One restoring division step: remainder, divisor, numerator bits, quotient.
    typedef struct packed {
        logic [9:0]  rem;
        logic [9:0]  div;
        logic [31:0] num;
        logic [31:0] quo;
    } t_div;

    // One CORDIC rotation step.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } t_rot;

    // Per-transaction context that travels beside the arithmetic.
    typedef struct packed {
        logic        kind;
        logic        oor;
        logic        pole_n;
        logic        pole_s;
        logic        tri_inner;
        logic        odd;
        logic [15:0] radius;
        logic [16:0] ca;
        logic [16:0] cb;
        logic [16:0] cc;
    } t_ctx;

    // Arctangent of 2^-k as a fraction of a turn (2^32 = one turn).
    function automatic logic signed [31:0] atan_turn(input logic [4:0] k);
        logic signed [31:0] a;
        unique case (k)
            5'd0:    a = 32'sh20000000;
            5'd1:    a = 32'sh12E4051E;
            5'd2:    a = 32'sh09FB385B;
            5'd3:    a = 32'sh051111D4;
            5'd4:    a = 32'sh028B0D43;
            5'd5:    a = 32'sh0145D7E1;
            5'd6:    a = 32'sh00A2F61E;
            5'd7:    a = 32'sh00517C55;
            5'd8:    a = 32'sh0028BE53;
            5'd9:    a = 32'sh00145F2F;
            5'd10:   a = 32'sh000A2F98;
            5'd11:   a = 32'sh000517CC;
            5'd12:   a = 32'sh00028BE6;
            5'd13:   a = 32'sh000145F3;
            5'd14:   a = 32'sh0000A2FA;
            5'd15:   a = 32'sh0000517D;
            5'd16:   a = 32'sh000028BE;
            5'd17:   a = 32'sh0000145F;
            5'd18:   a = 32'sh00000A30;
            5'd19:   a = 32'sh00000518;
            5'd20:   a = 32'sh0000028C;
            5'd21:   a = 32'sh00000146;
            5'd22:   a = 32'sh000000A3;
            5'd23:   a = 32'sh00000051;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

    // Saturate to the signed 17-bit output range.
    function automatic logic signed [16:0] sat17(input logic signed [47:0] v);
        logic signed [16:0] s;
        if (v > 48'sd65535) begin
            s = 17'sd65535;
        end else if (v < -48'sd65536) begin
            s = -17'sd65536;
        end else begin
            s = v[16:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/usmg_req_if.sv]
// ============================================================================
// Request channel
// Valid/ready channel carrying the request kind and item number.
// ============================================================================
`default_nettype none

interface usmg_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [16:0] item_number;

    modport source (output valid, output kind, output item_number, input ready);
    modport sink   (input valid, input kind, input item_number, output ready);
endinterface

`default_nettype wire

[rtl/usmg_rsp_if.sv]
// ============================================================================
// Result channel
// Valid/ready channel carrying a vertex position or triangle corners.
// ============================================================================
`default_nettype none

interface usmg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic [16:0]        corner_a;
    logic [16:0]        corner_b;
    logic [16:0]        corner_c;
    logic               out_of_range;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output corner_a, output corner_b, output corner_c,
                    output out_of_range, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input corner_a, input corner_b, input corner_c,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

[rtl/uv_sphere_mesh_generator_core.sv]
// ============================================================================
// UV sphere mesh generator core
// Returns vertex positions or triangle corner indices of a UV sphere.
// ============================================================================
// Throughput: one transaction per cycle unless a result waits at the output;
// the pipeline is a chain of 17 index division cells, 32 angle division cells
// and 16 CORDIC cells. The whole chain holds while a result waits to be taken.
// Reset clears all valid bits and loads radius 256, 5 stacks and 5 slices.
`default_nettype none

module uv_sphere_mesh_generator_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    usmg_req_if.sink   i_req,
    usmg_rsp_if.source o_rsp
);

    localparam int DIV1_N = usmg_pkg::DIV1_N;
    localparam int ANG_N  = usmg_pkg::ANG_N;
    localparam int ROT_N  = usmg_pkg::CORDIC_STAGES;
    localparam int S_PREP = usmg_pkg::S_PREP;
    localparam int S_QUAD = usmg_pkg::S_QUAD;
    localparam int S_MUL  = usmg_pkg::S_MUL;
    localparam int S_OUT  = usmg_pkg::S_OUT;

    // Configuration registers and derived counts.
    logic [15:0] r_radius;
    logic [8:0]  r_cfg_st;
    logic [8:0]  r_cfg_sl;
    logic [8:0]  r_st;
    logic [8:0]  r_sl;
    logic [8:0]  r_ring;
    logic [16:0] r_nv;
    logic [16:0] r_nt;
    logic [16:0] r_inner;
    logic [8:0]  n_st;
    logic [8:0]  n_sl;
    logic [8:0]  n_ring;
    logic [17:0] n_nv;
    logic [17:0] n_nt;
    logic [17:0] n_inner;

    logic                 w_en;
    logic [S_OUT:0]       r_vld;
    usmg_pkg::t_ctx       r_ctx [S_MUL+1];
    usmg_pkg::t_ctx       n_ctx0;
    usmg_pkg::t_ctx       n_ctxp;
    usmg_pkg::t_div       n_d1;
    usmg_pkg::t_div       w_d1 [DIV1_N];
    usmg_pkg::t_div       r_phi0;
    usmg_pkg::t_div       r_th0;
    usmg_pkg::t_div       n_phi0;
    usmg_pkg::t_div       n_th0;
    usmg_pkg::t_div       w_phi [ANG_N];
    usmg_pkg::t_div       w_th [ANG_N];
    usmg_pkg::t_rot       n_rp0;
    usmg_pkg::t_rot       n_rt0;
    usmg_pkg::t_rot       w_rp [ROT_N];
    usmg_pkg::t_rot       w_rt [ROT_N];

    // Entry decode signals.
    logic [16:0] w_u;
    logic [16:0] w_w;
    logic [16:0] w_south;
    logic [16:0] w_base;
    logic [16:0] w_bot_b;

    // Prep signals.
    logic [16:0] w_q;
    logic [8:0]  w_j;
    logic [16:0] w_iv;
    logic [25:0] w_iring;
    logic [16:0] w_up;
    logic [16:0] w_dn;

    // Quadrant, multiply and output registers.
    logic signed [31:0] r_cp, r_sp, r_ct, r_stt;
    logic signed [31:0] n_cp, n_sp, n_ct, n_stt;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [63:0] w_mx, w_my, w_mz;
    logic signed [63:0] w_rs;
    logic signed [63:0] w_fx, w_fz;
    logic signed [16:0] r_ox, r_oy, r_oz;
    logic [16:0]        r_oa, r_ob, r_oc;
    logic               r_oor;
    logic signed [16:0] n_ox, n_oy, n_oz;
    logic [16:0]        n_oa, n_ob, n_oc;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= usmg_pkg::RADIUS_RST;
            r_cfg_st <= usmg_pkg::STACKS_RST;
            r_cfg_sl <= usmg_pkg::SLICES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                usmg_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
                usmg_pkg::CFG_STACKS: r_cfg_st <= i_cfg_data[8:0];
                usmg_pkg::CFG_SLICES: r_cfg_sl <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamped counts and mesh sizes.
    always_comb begin
        if (r_cfg_st < usmg_pkg::MIN_STACKS) begin
            n_st = usmg_pkg::MIN_STACKS;
        end else if (r_cfg_st > usmg_pkg::MAX_STACKS) begin
            n_st = usmg_pkg::MAX_STACKS;
        end else begin
            n_st = r_cfg_st;
        end
        if (r_cfg_sl < usmg_pkg::MIN_SLICES) begin
            n_sl = usmg_pkg::MIN_SLICES;
        end else if (r_cfg_sl > usmg_pkg::MAX_SLICES) begin
            n_sl = usmg_pkg::MAX_SLICES;
        end else begin
            n_sl = r_cfg_sl;
        end
        n_ring  = n_sl + 9'd1;
        n_nv    = 18'(18'(n_st - 9'd1) * 18'(n_ring)) + 18'd2;
        n_nt    = 18'(18'({n_sl, 1'b0}) * 18'(n_st - 9'd1));
        n_inner = 18'(18'({n_sl, 1'b0}) * 18'(n_st - 9'd2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= usmg_pkg::STACKS_RST;
            r_sl    <= usmg_pkg::SLICES_RST;
            r_ring  <= 9'd6;
            r_nv    <= 17'd26;
            r_nt    <= 17'd40;
            r_inner <= 17'd30;
        end else begin
            r_st    <= n_st;
            r_sl    <= n_sl;
            r_ring  <= n_ring;
            r_nv    <= n_nv[16:0];
            r_nt    <= n_nt[16:0];
            r_inner <= n_inner[16:0];
        end
    end

    // The chain advances unless a finished result is held at the output.
    assign w_en        = !r_vld[S_OUT] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[S_OUT-1:0], i_req.valid};
        end
    end

    // Entry decode: range checks, cap corners and the index division setup.
    always_comb begin
        w_u     = i_req.item_number - {8'd0, r_sl};
        w_w     = w_u - r_inner;
        w_south = r_nv - 17'd1;
        w_base  = w_south - {8'd0, r_ring};
        w_bot_b = w_base + w_w;

        n_ctx0           = '0;
        n_ctx0.kind      = i_req.kind;
        n_ctx0.radius    = r_radius;
        n_ctx0.odd       = w_u[0];
        n_d1             = '0;
        if (i_req.kind == usmg_pkg::KIND_VERTEX) begin
            n_ctx0.oor    = (i_req.item_number >= r_nv);
            n_ctx0.pole_n = (i_req.item_number == 17'd0);
            n_ctx0.pole_s = (i_req.item_number == w_south);
            n_d1.div      = {1'b0, r_ring};
            n_d1.num      = {i_req.item_number - 17'd1, 15'd0};
        end else begin
            n_ctx0.oor = (i_req.item_number >= r_nt);
            n_d1.div   = {1'b0, r_sl};
            n_d1.num   = {1'b0, w_u[16:1], 15'd0};
            if (i_req.item_number < {8'd0, r_sl}) begin
                n_ctx0.cb = i_req.item_number + 17'd2;
                n_ctx0.cc = i_req.item_number + 17'd1;
            end else if (w_u < r_inner) begin
                n_ctx0.tri_inner = 1'b1;
            end else begin
                n_ctx0.ca = w_south;
                n_ctx0.cb = w_bot_b;
                n_ctx0.cc = w_bot_b + 17'd1;
            end
        end
    end

    // Index division chain.
    for (genvar g = 0; g < DIV1_N; g++) begin : g_div1
        if (g == 0) begin : g_first
            usmg_div_cell u_cell (
                .i_clk(i_clk), .i_en(w_en), .i_d(n_d1), .o_d(w_d1[g])
            );
        end else begin : g_rest
            usmg_div_cell u_cell (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_d1[g-1]), .o_d(w_d1[g])
            );
        end
    end

    // Prep: ring and position, inner quad corners and angle division setup.
    always_comb begin
        w_q     = w_d1[DIV1_N-1].quo[16:0];
        w_j     = w_d1[DIV1_N-1].rem[8:0];
        w_iv    = w_q + 17'd1;
        w_iring = 26'(w_q) * 26'(r_ring);
        w_up    = w_iring[16:0] + 17'd1 + {8'd0, w_j};
        w_dn    = w_up + {8'd0, r_ring};

        n_ctxp = r_ctx[S_PREP-1];
        if (r_ctx[S_PREP-1].tri_inner) begin
            if (!r_ctx[S_PREP-1].odd) begin
                n_ctxp.ca = w_up;
                n_ctxp.cb = w_up + 17'd1;
                n_ctxp.cc = w_dn;
            end else begin
                n_ctxp.ca = w_dn;
                n_ctxp.cb = w_up + 17'd1;
                n_ctxp.cc = w_dn + 17'd1;
            end
        end

        n_phi0.rem = w_iv[9:0];
        n_phi0.div = {r_st, 1'b0};
        n_phi0.num = {23'd0, r_st};
        n_phi0.quo = '0;
        n_th0.rem  = (w_j == r_sl) ? 10'd0 : {w_j, 1'b0};
        n_th0.div  = {r_sl, 1'b0};
        n_th0.num  = {23'd0, r_sl};
        n_th0.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phi0 <= n_phi0;
            r_th0  <= n_th0;
        end
    end

    // Context shift line, rewritten at the prep stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx[0] <= n_ctx0;
            for (int s = 1; s <= S_MUL; s++) begin
                r_ctx[s] <= (s == S_PREP) ? n_ctxp : r_ctx[s-1];
            end
        end
    end

    // Angle division chains for phi and theta.
    for (genvar g = 0; g < ANG_N; g++) begin : g_ang
        if (g == 0) begin : g_first
            usmg_div_cell u_phi (
                .i_clk(i_clk), .i_en(w_en), .i_d(r_phi0), .o_d(w_phi[g])
            );
            usmg_div_cell u_th (
                .i_clk(i_clk), .i_en(w_en), .i_d(r_th0), .o_d(w_th[g])
            );
        end else begin : g_rest
            usmg_div_cell u_phi (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_phi[g-1]), .o_d(w_phi[g])
            );
            usmg_div_cell u_th (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_th[g-1]), .o_d(w_th[g])
            );
        end
    end

    // CORDIC start: quadrant from the top bits, residual angle below.
    always_comb begin
        n_rp0.quad = w_phi[ANG_N-1].quo[31:30];
        n_rp0.z    = {2'b00, w_phi[ANG_N-1].quo[29:0]};
        n_rp0.x    = usmg_pkg::CORDIC_GAIN;
        n_rp0.y    = '0;
        n_rt0.quad = w_th[ANG_N-1].quo[31:30];
        n_rt0.z    = {2'b00, w_th[ANG_N-1].quo[29:0]};
        n_rt0.x    = usmg_pkg::CORDIC_GAIN;
        n_rt0.y    = '0;
    end

    // CORDIC chains for phi and theta.
    for (genvar g = 0; g < ROT_N; g++) begin : g_rot
        if (g == 0) begin : g_first
            usmg_rot_cell u_phi (
                .i_clk(i_clk), .i_en(w_en), .i_k(5'(g)), .i_d(n_rp0), .o_d(w_rp[g])
            );
            usmg_rot_cell u_th (
                .i_clk(i_clk), .i_en(w_en), .i_k(5'(g)), .i_d(n_rt0), .o_d(w_rt[g])
            );
        end else begin : g_rest
            usmg_rot_cell u_phi (
                .i_clk(i_clk), .i_en(w_en), .i_k(5'(g)), .i_d(w_rp[g-1]),
                .o_d(w_rp[g])
            );
            usmg_rot_cell u_th (
                .i_clk(i_clk), .i_en(w_en), .i_k(5'(g)), .i_d(w_rt[g-1]),
                .o_d(w_rt[g])
            );
        end
    end

    // Quadrant fold back to cosine and sine.
    always_comb begin
        unique case (w_rp[ROT_N-1].quad)
            2'd0: begin n_cp = w_rp[ROT_N-1].x;  n_sp = w_rp[ROT_N-1].y;  end
            2'd1: begin n_cp = -w_rp[ROT_N-1].y; n_sp = w_rp[ROT_N-1].x;  end
            2'd2: begin n_cp = -w_rp[ROT_N-1].x; n_sp = -w_rp[ROT_N-1].y; end
            default: begin n_cp = w_rp[ROT_N-1].y; n_sp = -w_rp[ROT_N-1].x; end
        endcase
        unique case (w_rt[ROT_N-1].quad)
            2'd0: begin n_ct = w_rt[ROT_N-1].x;  n_stt = w_rt[ROT_N-1].y;  end
            2'd1: begin n_ct = -w_rt[ROT_N-1].y; n_stt = w_rt[ROT_N-1].x;  end
            2'd2: begin n_ct = -w_rt[ROT_N-1].x; n_stt = -w_rt[ROT_N-1].y; end
            default: begin n_ct = w_rt[ROT_N-1].y; n_stt = -w_rt[ROT_N-1].x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cp  <= n_cp;
            r_sp  <= n_sp;
            r_ct  <= n_ct;
            r_stt <= n_stt;
        end
    end

    // First multiply: unit-sphere direction in Q2.30 and height scaled by the radius, both rounded.
    always_comb begin
        w_rs = 64'($signed({1'b0, r_ctx[S_QUAD].radius}));
        w_mx = ((64'(r_sp) * 64'(r_ct))  + 64'sh2000_0000) >>> 30;
        w_mz = ((64'(r_sp) * 64'(r_stt)) + 64'sh2000_0000) >>> 30;
        w_my = ((w_rs * 64'(r_cp))       + 64'sh2000_0000) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= w_mx[31:0];
            r_py <= w_my[31:0];
            r_pz <= w_mz[31:0];
        end
    end

    // Second multiply by the radius and the final result selection.
    always_comb begin
        w_fx = ((64'($signed({1'b0, r_ctx[S_MUL].radius})) * 64'(r_px))
                + 64'sh2000_0000) >>> 30;
        w_fz = ((64'($signed({1'b0, r_ctx[S_MUL].radius})) * 64'(r_pz))
                + 64'sh2000_0000) >>> 30;
        n_ox = '0;
        n_oy = '0;
        n_oz = '0;
        n_oa = '0;
        n_ob = '0;
        n_oc = '0;
        if (!r_ctx[S_MUL].oor) begin
            if (r_ctx[S_MUL].kind == usmg_pkg::KIND_VERTEX) begin
                if (r_ctx[S_MUL].pole_n) begin
                    n_oy = $signed({1'b0, r_ctx[S_MUL].radius});
                end else if (r_ctx[S_MUL].pole_s) begin
                    n_oy = -$signed({1'b0, r_ctx[S_MUL].radius});
                end else begin
                    n_ox = usmg_pkg::sat17(w_fx[47:0]);
                    n_oy = usmg_pkg::sat17(48'(r_py));
                    n_oz = usmg_pkg::sat17(w_fz[47:0]);
                end
            end else begin
                n_oa = r_ctx[S_MUL].ca;
                n_ob = r_ctx[S_MUL].cb;
                n_oc = r_ctx[S_MUL].cc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_oz  <= n_oz;
            r_oa  <= n_oa;
            r_ob  <= n_ob;
            r_oc  <= n_oc;
            r_oor <= r_ctx[S_MUL].oor;
        end
    end

    // Result channel.
    assign o_rsp.valid        = r_vld[S_OUT];
    assign o_rsp.pos_x        = r_ox;
    assign o_rsp.pos_y        = r_oy;
    assign o_rsp.pos_z        = r_oz;
    assign o_rsp.corner_a     = r_oa;
    assign o_rsp.corner_b     = r_ob;
    assign o_rsp.corner_c     = r_oc;
    assign o_rsp.out_of_range = r_oor;

endmodule

`default_nettype wire

[rtl/usmg_div_cell.sv]
// ============================================================================
// Division cell
// One registered restoring division step producing one quotient bit.
// ============================================================================
`default_nettype none

module usmg_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire usmg_pkg::t_div i_d,
    output usmg_pkg::t_div     o_d
);

    logic [10:0]    w_r2;
    logic           w_ge;
    logic [10:0]    w_diff;
    usmg_pkg::t_div n_d;
    usmg_pkg::t_div r_d;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        w_r2   = {i_d.rem, i_d.num[31]};
        w_ge   = (w_r2 >= {1'b0, i_d.div});
        w_diff = w_r2 - {1'b0, i_d.div};
        n_d.rem = w_ge ? w_diff[9:0] : w_r2[9:0];
        n_d.div = i_d.div;
        n_d.num = {i_d.num[30:0], 1'b0};
        n_d.quo = {i_d.quo[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

[rtl/usmg_rot_cell.sv]
// ============================================================================
// CORDIC rotation cell
// One registered rotation-mode CORDIC step; the step number comes from a port.
// ============================================================================
`default_nettype none

module usmg_rot_cell (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [4:0]     i_k,
    input  wire usmg_pkg::t_rot i_d,
    output usmg_pkg::t_rot      o_d
);

    logic signed [31:0] w_dx;
    logic signed [31:0] w_dy;
    logic signed [31:0] w_at;
    usmg_pkg::t_rot     n_d;
    usmg_pkg::t_rot     r_d;

    // Rotate toward zero residual angle; shifts round toward minus infinity.
    always_comb begin
        w_dx = i_d.y >>> i_k;
        w_dy = i_d.x >>> i_k;
        w_at = usmg_pkg::atan_turn(i_k);
        n_d.quad = i_d.quad;
        if (!i_d.z[31]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_at;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire
